FILE: hw/rtl/sgm_pkg.sv
package sgm_pkg;

    localparam int unsigned DEF_MAX_WIDTH    = 2048;
    localparam int unsigned DEF_MAX_HEIGHT   = 2048;
    localparam int unsigned DEF_MAX_CHANNELS = 4;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned DIM_CFG_W  = 12;
    localparam int unsigned CHAN_CFG_W = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned GRAD_W     = 11;
    localparam int unsigned SUM_W      = 21;
    localparam int unsigned OP_QUEUE_DEPTH  = 2;
    localparam int unsigned RES_QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [DIM_CFG_W-1:0]  RESET_WIDTH    = 12'd640;
    localparam logic [DIM_CFG_W-1:0]  RESET_HEIGHT   = 12'd480;
    localparam logic [CHAN_CFG_W-1:0] RESET_CHANNELS = 3'd1;

    // 255.5 squared is 65280.25, so anything above this saturates.
    localparam logic [SUM_W-1:0] ROOT_SAT_LIMIT = 21'd65280;

    typedef struct packed {
        logic       is_drain;
        logic       last;
        logic       emit;
        logic       compute;
        logic [1:0] ch;
    } op_ctl_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] magnitude;
        logic                last_of_frame;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SQUARE,
        BK_ROOT,
        BK_ROUND,
        BK_EMIT
    } back_state_t;

endpackage

FILE: hw/rtl/sgm_ram.sv
module sgm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sgm_queue.sv
module sgm_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == (PW + 1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/sgm_front.sv
module sgm_front #(
    parameter int unsigned MAX_WIDTH    = sgm_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT   = sgm_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned MAX_CHANNELS = sgm_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic                                  cmd,
    input  logic [sgm_pkg::SAMPLE_W-1:0]          sample,
    output logic                                  full,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  op_push,
    output sgm_pkg::op_ctl_t                      op_ctl,
    output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] op_idx,
    output logic [sgm_pkg::SAMPLE_W-1:0]          op_sample,
    input  logic                                  op_full
);

    localparam int unsigned AW  = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);
    localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HCW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned PNW = $clog2((MAX_WIDTH + 1) * MAX_CHANNELS + 1);

    logic [sgm_pkg::DIM_CFG_W-1:0]  width_reg, width_next;
    logic [sgm_pkg::DIM_CFG_W-1:0]  height_reg, height_next;
    logic [sgm_pkg::CHAN_CFG_W-1:0] chan_reg, chan_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [1:0]     ch_reg, ch_next;
    logic [PNW-1:0] pend_reg, pend_next;

    logic [WCW-1:0] eff_w;
    logic [HCW-1:0] eff_h;
    logic [sgm_pkg::CHAN_CFG_W-1:0] eff_c;
    logic           accept, cfg_write;
    logic [31:0]    total, delay;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    // An input request waits while a register write is offered.
    assign full      = op_full || cfg_valid;
    assign accept    = push && !full;

    always_comb
    begin
        if (width_reg == '0)
            eff_w = WCW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = WCW'(MAX_WIDTH);
        else
            eff_w = WCW'(width_reg);
        if (height_reg == '0)
            eff_h = HCW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = HCW'(MAX_HEIGHT);
        else
            eff_h = HCW'(height_reg);
        if (chan_reg == '0)
            eff_c = 3'd1;
        else if (32'(chan_reg) > MAX_CHANNELS)
            eff_c = 3'(MAX_CHANNELS);
        else
            eff_c = chan_reg;
    end

    assign total = 32'(eff_w) * 32'(eff_h) * 32'(eff_c);
    assign delay = (32'(eff_w) + 32'd1) * 32'(eff_c);

    assign op_idx    = AW'(32'(col_reg) * 32'(eff_c) + 32'(ch_reg));
    assign op_sample = sample;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        chan_next   = chan_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ch_next     = ch_reg;
        pend_next   = pend_reg;
        op_push     = 1'b0;
        op_ctl      = '0;
        op_ctl.ch   = ch_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                sgm_pkg::REG_IMAGE_WIDTH:   width_next  = cfg_data;
                sgm_pkg::REG_IMAGE_HEIGHT:  height_next = cfg_data;
                sgm_pkg::REG_CHANNEL_COUNT: chan_next   = cfg_data[sgm_pkg::CHAN_CFG_W-1:0];
                default: ;
            endcase
            // A write to a known register restarts the frame.
            if (cfg_index == sgm_pkg::REG_IMAGE_WIDTH || cfg_index == sgm_pkg::REG_IMAGE_HEIGHT
                || cfg_index == sgm_pkg::REG_CHANNEL_COUNT)
            begin
                col_next  = '0;
                row_next  = '0;
                ch_next   = '0;
                pend_next = '0;
            end
        end
        else if (accept)
        begin
            if (cmd == sgm_pkg::CMD_DRAIN || pend_reg != '0)
            begin
                if (pend_reg != '0)
                begin
                    pend_next       = pend_reg - 1'b1;
                    op_push         = 1'b1;
                    op_ctl.is_drain = 1'b1;
                    op_ctl.last     = (pend_reg == PNW'(1));
                end
            end
            else
            begin
                op_push        = 1'b1;
                op_ctl.emit    = (row_reg >= RW'(2)) || (row_reg == RW'(1) && col_reg >= CW'(1));
                op_ctl.compute = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
                if ({1'b0, ch_reg} + 3'd1 >= eff_c)
                begin
                    ch_next = '0;
                    if (WCW'(col_reg) + WCW'(1) >= eff_w)
                    begin
                        col_next = '0;
                        if (HCW'(row_reg) + HCW'(1) >= eff_h)
                        begin
                            row_next  = '0;
                            pend_next = PNW'((total < delay) ? total : delay);
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sgm_pkg::RESET_WIDTH;
            height_reg <= sgm_pkg::RESET_HEIGHT;
            chan_reg   <= sgm_pkg::RESET_CHANNELS;
            col_reg    <= '0;
            row_reg    <= '0;
            ch_reg     <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            chan_reg   <= chan_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ch_reg     <= ch_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

FILE: hw/rtl/sgm_back.sv
module sgm_back #(
    parameter int unsigned MAX_WIDTH    = sgm_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_CHANNELS = sgm_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      op_empty,
    output logic                                      op_pop,
    input  sgm_pkg::op_ctl_t                          op_ctl,
    input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] op_idx,
    input  logic [sgm_pkg::SAMPLE_W-1:0]              op_sample,
    output logic                                      res_push,
    output sgm_pkg::result_t                          res_data,
    input  logic                                      res_full
);

    localparam int unsigned AW    = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned SW    = sgm_pkg::SAMPLE_W;
    localparam int unsigned GW    = sgm_pkg::GRAD_W;

    sgm_pkg::back_state_t state_reg, state_next;
    sgm_pkg::op_ctl_t     ctl_reg, ctl_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [SW-1:0]        sample_reg, sample_next;
    logic [SW-1:0]        win_reg [MAX_CHANNELS][6];
    logic [SW-1:0]        lane [6];
    logic signed [GW-1:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [sgm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [SW-1:0]        root_reg, root_next;
    logic [2:0]           bit_reg, bit_next;
    logic [SW-1:0]        mag_reg, mag_next;

    logic                 ram_re, ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [SW-1:0]        top, mid;
    logic signed [GW-1:0] q00, q01, q02, q10, q12, q20, q21, q22;
    logic signed [2*GW-1:0] sqx, sqy;
    logic [SW-1:0]        trial;
    logic [15:0]          trial_sq, round_lim;
    logic                 sat;
    logic [CHW-1:0]       lane_sel;

    assign ram_raddr = op_idx;
    assign lane_sel  = ctl_reg.ch[CHW-1:0];

    sgm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_line_above (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (mid),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (top)
    );

    sgm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_line_middle (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (mid)
    );

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            lane[k] = win_reg[lane_sel][k];
        end
    end

    // Window after the shift: the two older columns come from the stored lane,
    // the newest from the two line stores and the incoming sample.
    assign q00 = $signed({3'b000, lane[0]});
    assign q01 = $signed({3'b000, lane[1]});
    assign q02 = $signed({3'b000, top});
    assign q10 = $signed({3'b000, lane[2]});
    assign q12 = $signed({3'b000, mid});
    assign q20 = $signed({3'b000, lane[4]});
    assign q21 = $signed({3'b000, lane[5]});
    assign q22 = $signed({3'b000, sample_reg});

    assign sqx       = gx_reg * gx_reg;
    assign sqy       = gy_reg * gy_reg;
    assign trial     = root_reg | (SW'(1) << bit_reg);
    assign trial_sq  = {8'b0, trial} * {8'b0, trial};
    assign round_lim = {8'b0, root_reg} * {8'b0, root_reg} + {8'b0, root_reg};
    assign sat       = sum_reg > sgm_pkg::ROOT_SAT_LIMIT;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sgm_pkg::BK_IDLE:
            begin
                if (!op_empty)
                    state_next = op_ctl.is_drain ? sgm_pkg::BK_EMIT : sgm_pkg::BK_EXEC;
            end
            sgm_pkg::BK_EXEC:
            begin
                if (!ctl_reg.emit)
                    state_next = sgm_pkg::BK_IDLE;
                else if (!ctl_reg.compute)
                    state_next = sgm_pkg::BK_EMIT;
                else
                    state_next = sgm_pkg::BK_SQUARE;
            end
            sgm_pkg::BK_SQUARE: state_next = sgm_pkg::BK_ROOT;
            sgm_pkg::BK_ROOT:
            begin
                if (sat)
                    state_next = sgm_pkg::BK_EMIT;
                else if (bit_reg == 3'd0)
                    state_next = sgm_pkg::BK_ROUND;
            end
            sgm_pkg::BK_ROUND: state_next = sgm_pkg::BK_EMIT;
            sgm_pkg::BK_EMIT:
            begin
                if (!res_full)
                    state_next = sgm_pkg::BK_IDLE;
            end
            default: state_next = sgm_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        op_pop   = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            sgm_pkg::BK_IDLE:
            begin
                op_pop = !op_empty;
                ram_re = !op_empty;
            end
            sgm_pkg::BK_EXEC:  ram_we   = 1'b1;
            sgm_pkg::BK_EMIT:  res_push = !res_full;
            default: ;
        endcase
    end

    assign res_data.magnitude     = mag_reg;
    assign res_data.last_of_frame = ctl_reg.last;

    always_comb
    begin
        ctl_next    = ctl_reg;
        idx_next    = idx_reg;
        sample_next = sample_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        sum_next    = sum_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        mag_next    = mag_reg;
        case (state_reg)
            sgm_pkg::BK_IDLE:
            begin
                ctl_next    = op_ctl;
                idx_next    = op_idx;
                sample_next = op_sample;
                mag_next    = '0;
            end
            sgm_pkg::BK_EXEC:
            begin
                gx_next = q22 - q20 + q02 - q00 + ((q12 - q10) <<< 1);
                gy_next = q20 + q22 - q00 - q02 + ((q21 - q01) <<< 1);
            end
            sgm_pkg::BK_SQUARE:
            begin
                sum_next  = sgm_pkg::SUM_W'(sqx + sqy);
                root_next = '0;
                bit_next  = 3'd7;
            end
            sgm_pkg::BK_ROOT:
            begin
                if (sat)
                    mag_next = '1;
                else
                begin
                    if ({5'b0, trial_sq} <= sum_reg)
                        root_next = trial;
                    bit_next = bit_reg - 3'd1;
                end
            end
            sgm_pkg::BK_ROUND:
            begin
                mag_next = (sum_reg > {5'b0, round_lim}) ? root_reg + 1'b1 : root_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgm_pkg::BK_IDLE;
            ctl_reg   <= '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                for (int k = 0; k < 6; k++)
                begin
                    win_reg[c][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            ctl_reg   <= ctl_next;
            if (state_reg == sgm_pkg::BK_EXEC)
            begin
                win_reg[lane_sel][0] <= lane[1];
                win_reg[lane_sel][1] <= top;
                win_reg[lane_sel][2] <= lane[3];
                win_reg[lane_sel][3] <= mid;
                win_reg[lane_sel][4] <= lane[5];
                win_reg[lane_sel][5] <= sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sample_reg <= sample_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        sum_reg    <= sum_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        mag_reg    <= mag_next;
    end

endmodule

FILE: hw/rtl/sobel_gradient_magnitude.sv
// Channel   Direction  Handshake              Payload
// input     in         push / full            cmd, sample
// result    out        pop / empty            magnitude, last_of_frame
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one request per cycle while its two-entry queue has room and no register write is offered.
// The back takes one op at a time: a drain is emitted at once, a silent pixel ends after
// its execute step, a border result is emitted after it, and an interior result is squared,
// passed through the bit-per-cycle square root unit (left early on saturation) and rounded.
// Reset clears control and window state; the line stores are not cleared.
// A full result queue stalls the back; a full op queue or a register write raises full.
module sobel_gradient_magnitude #(
    parameter int unsigned MAX_WIDTH    = sgm_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT   = sgm_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned MAX_CHANNELS = sgm_pkg::DEF_MAX_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           cmd,
    input  logic [sgm_pkg::SAMPLE_W-1:0]   sample,
    output logic                           empty,
    input  logic                           pop,
    output logic [sgm_pkg::SAMPLE_W-1:0]   magnitude,
    output logic                           last_of_frame,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned AW  = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int unsigned OPW = $bits(sgm_pkg::op_ctl_t) + AW + sgm_pkg::SAMPLE_W;
    localparam int unsigned RSW = $bits(sgm_pkg::result_t);

    logic                          op_push, op_full, op_pop, op_empty;
    sgm_pkg::op_ctl_t              f_ctl, b_ctl;
    logic [AW-1:0]                 f_idx, b_idx;
    logic [sgm_pkg::SAMPLE_W-1:0]  f_sample, b_sample;
    logic                          res_push, res_full;
    sgm_pkg::result_t              res_in, res_out;

    sgm_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (cmd),
        .sample    (sample),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_push   (op_push),
        .op_ctl    (f_ctl),
        .op_idx    (f_idx),
        .op_sample (f_sample),
        .op_full   (op_full)
    );

    sgm_queue #(.WIDTH(OPW), .DEPTH(sgm_pkg::OP_QUEUE_DEPTH)) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_data ({f_ctl, f_idx, f_sample}),
        .full      (op_full),
        .pop       (op_pop),
        .empty     (op_empty),
        .pop_data  ({b_ctl, b_idx, b_sample})
    );

    sgm_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .op_ctl    (b_ctl),
        .op_idx    (b_idx),
        .op_sample (b_sample),
        .res_push  (res_push),
        .res_data  (res_in),
        .res_full  (res_full)
    );

    sgm_queue #(.WIDTH(RSW), .DEPTH(sgm_pkg::RES_QUEUE_DEPTH)) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (res_out)
    );

    assign magnitude     = res_out.magnitude;
    assign last_of_frame = res_out.last_of_frame;

    // Drain results lie on the frame border, so the final one is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_frame) |-> (magnitude == '0))
        else $error("last_of_frame result with nonzero magnitude");

    assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> !op_empty)
        else $error("back popped an empty op queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        op_push |-> !op_full)
        else $error("front pushed into a full op queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("back pushed into a full result queue");

endmodule

FILE: bench/tb_top.sv
module tb_top;

    typedef logic [sgm_pkg::SAMPLE_W-1:0]   sample_t;
    typedef logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data_t;

    // Software copy of the filter: configuration, position counters, line
    // stores, per-channel windows and the queue of results still owed.
    class sobel_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned chan_reg;
        logic [sgm_pkg::SAMPLE_W-1:0] row_top[8192];
        logic [sgm_pkg::SAMPLE_W-1:0] row_mid[8192];
        int win[4][3][3];
        int unsigned in_row;
        int unsigned in_col;
        int unsigned in_ch;
        int unsigned pending;
        sgm_pkg::result_t expected_q[$];
        int errors;

        function new();
            width_reg  = sgm_pkg::RESET_WIDTH;
            height_reg = sgm_pkg::RESET_HEIGHT;
            chan_reg   = sgm_pkg::RESET_CHANNELS;
            foreach (row_top[i]) begin
                row_top[i] = '0;
                row_mid[i] = '0;
            end
            foreach (win[c, r, k]) win[c][r][k] = 0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_row  = 0;
            in_col  = 0;
            in_ch   = 0;
            pending = 0;
        endfunction

        function void write_reg(logic [sgm_pkg::CFG_IDX_W-1:0] idx,
                                logic [sgm_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sgm_pkg::REG_IMAGE_WIDTH:   width_reg  = val[sgm_pkg::DIM_CFG_W-1:0];
                sgm_pkg::REG_IMAGE_HEIGHT:  height_reg = val[sgm_pkg::DIM_CFG_W-1:0];
                sgm_pkg::REG_CHANNEL_COUNT: chan_reg   = val[sgm_pkg::CHAN_CFG_W-1:0];
                default:                    return;
            endcase
            restart();
        endfunction

        function int unsigned clamped(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        // Nearest integer square root, halves rounding up, saturated at 255.
        function logic [sgm_pkg::SAMPLE_W-1:0] round_root(int unsigned s);
            int unsigned n;
            n = 0;
            if (s > sgm_pkg::ROOT_SAT_LIMIT) return 8'd255;
            for (int unsigned b = 128; b != 0; b = b >> 1)
                if ((n | b) * (n | b) <= s) n = n | b;
            if (s > n * n + n) n++;
            return (n > 255) ? 8'd255 : n[7:0];
        endfunction

        function void note_request(logic c, logic [sgm_pkg::SAMPLE_W-1:0] s);
            int unsigned w, h, nch, idx;
            int gx, gy;
            sgm_pkg::result_t res;
            logic [sgm_pkg::SAMPLE_W-1:0] top, mid;
            bit emit;
            w   = clamped(width_reg, sgm_pkg::DEF_MAX_WIDTH);
            h   = clamped(height_reg, sgm_pkg::DEF_MAX_HEIGHT);
            nch = clamped(chan_reg, sgm_pkg::DEF_MAX_CHANNELS);
            // A pixel that arrives while drains are due is taken as a drain.
            if (c == sgm_pkg::CMD_DRAIN || pending != 0) begin
                if (pending == 0) return;
                pending--;
                res.magnitude     = '0;
                res.last_of_frame = (pending == 0);
                expected_q.push_back(res);
                return;
            end
            idx = in_col * nch + in_ch;
            if (idx > 8191) idx = 8191;
            top = row_top[idx];
            mid = row_mid[idx];
            row_top[idx] = mid;
            row_mid[idx] = s;
            for (int r = 0; r < 3; r++) begin
                win[in_ch][r][0] = win[in_ch][r][1];
                win[in_ch][r][1] = win[in_ch][r][2];
            end
            win[in_ch][0][2] = top;
            win[in_ch][1][2] = mid;
            win[in_ch][2][2] = s;
            emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
            if (emit) begin
                res.magnitude     = '0;
                res.last_of_frame = 1'b0;
                if (in_row >= 2 && in_col >= 2) begin
                    gx = win[in_ch][0][2] - win[in_ch][0][0]
                       + 2 * (win[in_ch][1][2] - win[in_ch][1][0])
                       + win[in_ch][2][2] - win[in_ch][2][0];
                    gy = win[in_ch][2][0] - win[in_ch][0][0]
                       + 2 * (win[in_ch][2][1] - win[in_ch][0][1])
                       + win[in_ch][2][2] - win[in_ch][0][2];
                    res.magnitude = round_root(gx * gx + gy * gy);
                end
                expected_q.push_back(res);
            end
            in_ch++;
            if (in_ch >= nch) begin
                in_ch = 0;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= h) begin
                        in_row  = 0;
                        pending = (w * h * nch < (w + 1) * nch) ? w * h * nch
                                                               : (w + 1) * nch;
                    end
                end
            end
        endfunction

        function void check_result(logic [sgm_pkg::SAMPLE_W-1:0] mag, logic last);
            sgm_pkg::result_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result magnitude=%0d last=%0b", $time, mag, last);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (mag !== exp_res.magnitude) begin
                $display("%0t: magnitude expected %0d actual %0d",
                         $time, exp_res.magnitude, mag);
                errors++;
            end
            if (last !== exp_res.last_of_frame) begin
                $display("%0t: last_of_frame expected %0b actual %0b",
                         $time, exp_res.last_of_frame, last);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           push;
    logic                           full;
    logic                           cmd;
    logic [sgm_pkg::SAMPLE_W-1:0]   sample;
    logic                           empty;
    logic                           pop;
    logic [sgm_pkg::SAMPLE_W-1:0]   magnitude;
    logic                           last_of_frame;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data;

    sobel_scoreboard sb;
    bit no_gaps;
    int results_seen;

    sobel_gradient_magnitude u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .sample        (sample),
        .empty         (empty),
        .pop           (pop),
        .magnitude     (magnitude),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic c, logic [sgm_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push   <= 1'b1;
        cmd    <= c;
        sample <= s;
        do @(posedge clk); while (full);
        sb.note_request(c, s);
    endtask

    // Registers change only once every owed result has left the block.
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        push <= 1'b0;
        while (sb.expected_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [sgm_pkg::CFG_IDX_W-1:0] idx,
                             logic [sgm_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned nch);
        wait_idle();
        write_reg(sgm_pkg::REG_IMAGE_WIDTH, cfg_data_t'(w));
        write_reg(sgm_pkg::REG_IMAGE_HEIGHT, cfg_data_t'(h));
        write_reg(sgm_pkg::REG_CHANNEL_COUNT, cfg_data_t'(nch));
    endtask

    // One frame of random samples, at times cut short, with the odd stray drain, then
    // the drains it owes and up to two more; owed drains may go as pixels, whose samples drop.
    task automatic random_frame(int unsigned total, bit cut_short, output int unsigned sent);
        int unsigned n;
        n = cut_short ? $urandom_range(1, total) : total;
        sent = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(sgm_pkg::CMD_DRAIN, sample_t'($urandom));
                sent++;
            end
            send_item(sgm_pkg::CMD_PIXEL, sample_t'($urandom));
            sent++;
        end
        while (sb.pending != 0)
        begin
            send_item($urandom_range(0, 3) == 0 ? sgm_pkg::CMD_PIXEL : sgm_pkg::CMD_DRAIN,
                      sample_t'($urandom));
            sent++;
        end
        repeat ($urandom_range(0, 2))
        begin
            send_item(sgm_pkg::CMD_DRAIN, sample_t'($urandom));
            sent++;
        end
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned budget;
        int unsigned w_cfg[8] = '{5, 3, 0, 7, 4, 6, 4095, 2};
        int unsigned h_cfg[8] = '{4, 3, 2, 5, 3, 6, 1, 2};
        int unsigned c_cfg[8] = '{2, 1, 0, 3, 4, 7, 4, 1};
        sb = new();
        rst_n     = 1'b0;
        push      = 1'b0;
        cmd       = sgm_pkg::CMD_PIXEL;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = sgm_pkg::REG_IMAGE_WIDTH;
        cfg_data  = '0;
        no_gaps   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A write to the unused index must leave the settings alone.
        write_reg(2'd3, 12'hFFF);
        // 4x4 checkerboard of the extremes: the gradients of every window cancel.
        set_frame(4, 4, 1);
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++)
                send_item(sgm_pkg::CMD_PIXEL, ((r + k) % 2 == 1) ? 8'hFF : 8'h00);
        send_item(sgm_pkg::CMD_PIXEL, 8'hAA);
        for (int i = 0; i < 4; i++)
            send_item(sgm_pkg::CMD_DRAIN, 8'h00);
        send_item(sgm_pkg::CMD_DRAIN, 8'h55);
        // A one-pixel frame gives its only result through a drain.
        set_frame(1, 1, 1);
        send_item(sgm_pkg::CMD_PIXEL, 8'hFF);
        send_item(sgm_pkg::CMD_DRAIN, 8'h00);

        for (int p = 0; p < 8; p++)
        begin
            set_frame(w_cfg[p], h_cfg[p], c_cfg[p]);
            no_gaps = (p % 3 == 2);
            if (w_cfg[p] == 4095)
            begin
                // Only the start of a clamped wide row; the next write restarts.
                for (int i = 0; i < 60; i++)
                    send_item(sgm_pkg::CMD_PIXEL, sample_t'($urandom));
            end
            else
            begin
                budget = 90;
                while (budget > 0)
                begin
                    random_frame(sb.clamped(w_cfg[p], sgm_pkg::DEF_MAX_WIDTH)
                                 * sb.clamped(h_cfg[p], sgm_pkg::DEF_MAX_HEIGHT)
                                 * sb.clamped(c_cfg[p], sgm_pkg::DEF_MAX_CHANNELS),
                                 $urandom_range(0, 7) == 0, sent);
                    budget = (sent >= budget) ? 0 : budget - sent;
                end
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    always
    begin
        @(negedge clk);
        if (results_seen == 150)
        begin
            pop <= 1'b0;
            results_seen++;
            repeat (400) @(negedge clk);
        end
        pop <= ($urandom_range(0, 9) < 7) || no_gaps;
    end

    initial
    begin
        results_seen = 0;
        pop = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_result(magnitude, last_of_frame);
            if (results_seen != 151) results_seen <= results_seen + 1;
        end
    end

    initial
    begin
        #50000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
